[hw/rtl/lpgg_pkg.sv]
// ----------------------------------------------------------------------------
// lpgg_pkg
// Shared constants and register indexes of the preferential graph grower.
// ----------------------------------------------------------------------------
package lpgg_pkg;

    localparam int MAX_NODES_DEF   = 8192;
    localparam int DEGREE_BITS_DEF = 16;
    localparam int NODE_W          = 14;
    localparam int DRAW_W          = 16;

    localparam logic [2:0] REG_LINK_PROB  = 3'd0;
    localparam logic [2:0] REG_OFFSET     = 3'd1;
    localparam logic [2:0] REG_LOW_COUNT  = 3'd2;
    localparam logic [2:0] REG_COUNT_PROB = 3'd3;
    localparam logic [2:0] REG_SEED       = 3'd4;

    localparam logic REQ_RESTART = 1'b0;
    localparam logic REQ_GROW    = 1'b1;

endpackage

[hw/rtl/lpgg_degree_ram.sv]
// ----------------------------------------------------------------------------
// lpgg_degree_ram
// Degree store: one write port, one registered read port.
// ----------------------------------------------------------------------------
module lpgg_degree_ram #(
    parameter int DEPTH = lpgg_pkg::MAX_NODES_DEF,
    parameter int WIDTH = lpgg_pkg::DEGREE_BITS_DEF
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write, then registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[hw/rtl/linear_preference_graph_growth.sv]
// Restart: one clearing/seed sweep over all MAX_NODES+1 store words, no result.
// Growth step with n nodes: a sum scan over the n stored degrees, one selection
// scan evaluating all six thresholds at once, then up to six read-modify-write
// updates (read, wait, write back); results follow one a cycle while out_ready is high.
// A new request is taken only in the idle state, so one request is in flight at a time.
// Reset clears control state and the node count, then sweeps the store to zero.
// ----------------------------------------------------------------------------
// linear_preference_graph_growth
// Grows a power-law graph by generalized linear preference over a degree RAM.
// ----------------------------------------------------------------------------
module linear_preference_graph_growth #(
    parameter int MAX_NODES   = lpgg_pkg::MAX_NODES_DEF,
    parameter int DEGREE_BITS = lpgg_pkg::DEGREE_BITS_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [16:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        req_type,
    input  logic [15:0] step_draw,
    input  logic [15:0] count_draw,
    input  logic [15:0] from_draw_a,
    input  logic [15:0] from_draw_b,
    input  logic [15:0] from_draw_c,
    input  logic [15:0] to_draw_a,
    input  logic [15:0] to_draw_b,
    input  logic [15:0] to_draw_c,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [13:0] edge_source,
    output logic [13:0] edge_target,
    output logic        from_new_node,
    output logic        last_edge
);

    localparam int AW  = $clog2(MAX_NODES + 1);
    localparam int CW  = $clog2(MAX_NODES + 2);
    localparam int SW  = DEGREE_BITS + 8 + CW + 1;
    localparam int PW  = SW + 17;
    localparam logic [DEGREE_BITS-1:0] DMAX = '1;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CLEAR = 3'd1;
    localparam logic [2:0] S_SUM   = 3'd2;
    localparam logic [2:0] S_SEL   = 3'd3;
    localparam logic [2:0] S_UPD   = 3'd4;
    localparam logic [2:0] S_EMIT  = 3'd5;

    // configuration
    logic [15:0] link_prob_reg;
    logic [15:0] offset_reg;
    logic [1:0]  low_cnt_reg;
    logic [16:0] cnt_prob_reg;
    logic [13:0] seed_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_prob_reg <= 16'd43691;
            offset_reg    <= 16'd9472;
            low_cnt_reg   <= 2'd2;
            cnt_prob_reg  <= 17'd65536;
            seed_reg      <= 14'd20;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                lpgg_pkg::REG_LINK_PROB:  link_prob_reg <= cfg_data[15:0];
                lpgg_pkg::REG_OFFSET:     offset_reg    <= cfg_data[15:0];
                lpgg_pkg::REG_LOW_COUNT:  low_cnt_reg   <= cfg_data[1:0];
                lpgg_pkg::REG_COUNT_PROB: cnt_prob_reg  <= cfg_data;
                lpgg_pkg::REG_SEED:       seed_reg      <= cfg_data[13:0];
                default: ;
            endcase
        end
    end

    // control and payload state
    logic [2:0]            state_reg;
    logic [CW-1:0]         n_reg;
    logic [CW-1:0]         seed_n_reg;
    logic [CW-1:0]         idx_reg;
    logic                  rd_pend_reg;
    logic [CW-1:0]         rd_idx_reg;
    logic signed [SW-1:0]  total_reg;
    logic signed [SW-1:0]  prefix_reg;
    logic                  links_reg;
    logic [1:0]            count_reg;
    logic [15:0]           draw_reg [6];
    logic [5:0]            found_reg;
    logic [CW-1:0]         pick_reg [6];
    logic signed [PW-1:0]  lhs_reg [6];
    logic [2:0]            upd_reg;
    logic [1:0]            uph_reg;
    logic [1:0]            emit_reg;

    // memory
    logic                   we;
    logic [AW-1:0]          waddr, raddr;
    logic [DEGREE_BITS-1:0] wdata, rdata;

    lpgg_degree_ram #(.DEPTH(MAX_NODES + 1), .WIDTH(DEGREE_BITS)) u_ram (
        .clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // clamped seed size and edge count
    logic [CW-1:0] seed_c;
    logic [1:0]    low_c;
    always_comb
    begin
        if (seed_reg < 14'd2)
            seed_c = CW'(2);
        else if ({{(CW+1){1'b0}}, seed_reg} > (CW+15)'(MAX_NODES))
            seed_c = CW'(MAX_NODES);
        else
            seed_c = CW'(seed_reg);
        low_c = (low_cnt_reg == 2'd0) ? 2'd1 : ((low_cnt_reg == 2'd3) ? 2'd2 : low_cnt_reg);
    end

    // weight of the word just read
    logic signed [SW-1:0] weight, prefix_new;
    logic signed [PW-1:0] rhs;
    assign weight = $signed({1'b0, {(SW-DEGREE_BITS-9){1'b0}}, rdata, 8'd0})
                  - SW'($signed(offset_reg));
    assign prefix_new = prefix_reg + weight;
    assign rhs = {prefix_new[SW-1], prefix_new, 16'd0};

    // update sequencing: slot u<3 is source u, 3<=u<6 is target u-3, u==6 is the new node
    logic [CW-1:0] upd_node;
    logic          upd_active;
    logic [2:0]    upd_lim;
    always_comb
    begin
        upd_lim = 3'(count_reg) + 3'd3;
        upd_active = (upd_reg < 3'(count_reg)) ? links_reg : 1'b1;
        if (upd_reg == 3'd6)
        begin
            upd_node = n_reg + 1'b1;
            upd_active = !links_reg;
        end
        else
            upd_node = pick_reg[upd_reg];
    end

    logic in_fire;
    assign in_fire = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);

    logic [15:0] draw_in [6];
    assign draw_in[0] = from_draw_a;
    assign draw_in[1] = from_draw_b;
    assign draw_in[2] = from_draw_c;
    assign draw_in[3] = to_draw_a;
    assign draw_in[4] = to_draw_b;
    assign draw_in[5] = to_draw_c;

    // memory port drive
    always_comb
    begin
        we = 1'b0;
        waddr = AW'(idx_reg);
        wdata = '0;
        raddr = AW'(idx_reg);
        if (state_reg == S_CLEAR)
        begin
            we = 1'b1;
            if (idx_reg == 0 || idx_reg > seed_n_reg)
                wdata = '0;
            else if (idx_reg == 1 || idx_reg == seed_n_reg)
                wdata = DEGREE_BITS'(1);
            else
                wdata = DEGREE_BITS'(2);
        end
        else if (state_reg == S_UPD)
        begin
            raddr = AW'(upd_node);
            waddr = AW'(upd_node);
            if (uph_reg == 2'd2 && upd_active)
            begin
                we = 1'b1;
                if (upd_reg == 3'd6)
                    wdata = DEGREE_BITS'(count_reg);
                else
                    wdata = (rdata == DMAX) ? rdata : rdata + 1'b1;
            end
        end
    end

    // main sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            n_reg       <= '0;
            seed_n_reg  <= '0;
            idx_reg     <= '0;
            rd_pend_reg <= 1'b0;
            upd_reg     <= '0;
            uph_reg     <= '0;
            emit_reg    <= '0;
            found_reg   <= '0;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (in_fire)
                    begin
                        if (req_type == lpgg_pkg::REQ_RESTART)
                        begin
                            seed_n_reg <= seed_c;
                            n_reg      <= seed_c;
                            idx_reg    <= '0;
                            state_reg  <= S_CLEAR;
                        end
                        else if (n_reg != 0 && n_reg < CW'(MAX_NODES))
                        begin
                            links_reg <= step_draw < link_prob_reg;
                            count_reg <= ({1'b0, count_draw} < cnt_prob_reg)
                                       ? low_c : low_c + 2'd1;
                            for (int j = 0; j < 6; j++)
                                draw_reg[j] <= draw_in[j];
                            idx_reg     <= CW'(1);
                            rd_pend_reg <= 1'b0;
                            prefix_reg  <= '0;
                            state_reg   <= S_SUM;
                        end
                    end
                end
                S_CLEAR:
                begin
                    idx_reg <= idx_reg + 1'b1;
                    if (idx_reg == CW'(MAX_NODES))
                        state_reg <= S_IDLE;
                end
                S_SUM:
                begin
                    rd_pend_reg <= (idx_reg <= n_reg);
                    idx_reg     <= idx_reg + 1'b1;
                    if (rd_pend_reg)
                        prefix_reg <= prefix_new;
                    else if (idx_reg > n_reg)
                    begin
                        total_reg <= prefix_reg;
                        for (int j = 0; j < 6; j++)
                        begin
                            lhs_reg[j] <= $signed({1'b0, draw_reg[j]}) * prefix_reg;
                            pick_reg[j] <= n_reg;
                        end
                        found_reg   <= (prefix_reg == 0) ? 6'h3F : 6'h00;
                        prefix_reg  <= '0;
                        idx_reg     <= CW'(1);
                        rd_pend_reg <= 1'b0;
                        state_reg   <= S_SEL;
                    end
                end
                S_SEL:
                begin
                    rd_pend_reg <= (idx_reg <= n_reg);
                    rd_idx_reg  <= idx_reg;
                    idx_reg     <= idx_reg + 1'b1;
                    if (rd_pend_reg)
                    begin
                        prefix_reg <= prefix_new;
                        for (int j = 0; j < 6; j++)
                        begin
                            if (!found_reg[j] &&
                                ((total_reg > 0) ? (lhs_reg[j] <= rhs)
                                                 : (lhs_reg[j] >= rhs)))
                            begin
                                found_reg[j] <= 1'b1;
                                pick_reg[j]  <= rd_idx_reg;
                            end
                        end
                    end
                    else if (idx_reg > n_reg)
                    begin
                        upd_reg   <= links_reg ? 3'd0 : 3'd6;
                        uph_reg   <= '0;
                        state_reg <= S_UPD;
                    end
                end
                S_UPD:
                begin
                    // read, wait, write back; one slot at a time
                    uph_reg <= uph_reg + 1'b1;
                    if (uph_reg == 2'd2)
                    begin
                        uph_reg <= '0;
                        if (upd_reg == 3'd6)
                            upd_reg <= 3'd3;
                        else if (upd_reg == 3'(count_reg) - 3'd1)
                            upd_reg <= 3'd3;
                        else if (upd_reg + 3'd1 == upd_lim)
                        begin
                            if (!links_reg)
                                n_reg <= n_reg + 1'b1;
                            emit_reg  <= '0;
                            state_reg <= S_EMIT;
                        end
                        else
                            upd_reg <= upd_reg + 3'd1;
                    end
                end
                S_EMIT:
                begin
                    if (out_ready)
                    begin
                        emit_reg <= emit_reg + 1'b1;
                        if (emit_reg + 2'd1 == count_reg)
                            state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // result drive
    logic [CW-1:0] src_n;
    assign src_n = links_reg ? pick_reg[3'(emit_reg)] : n_reg;
    assign out_valid     = (state_reg == S_EMIT);
    assign edge_source   = 14'(src_n);
    assign edge_target   = 14'(pick_reg[3'(emit_reg) + 3'd3]);
    assign from_new_node = !links_reg;
    assign last_edge     = (emit_reg + 2'd1 == count_reg);

endmodule
